// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/proq_pkg.sv =====
package proq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_W       = 5;
    localparam int OCC_W       = 5;
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_BUMP_COND = 2'd1;
    localparam logic [1:0] OP_BUMP_ANY  = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_POPPED  = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [7:0]  handle;
        logic [31:0] order;
    } t_entry;

endpackage

// ===== sv/poc_reorder_output_queue_top.sv =====
// Flow: push, clear and a bump that releases nothing go from accept through S_DONE to the
//   output register; a pop with N entries held passes S_SCAN and S_SHIFT first.
// One item at a time: N scan reads, up to N - 1 shift moves, the shift drain and the
//   move to the output register; the next item is then taken in S_IDLE.
//   An output stall holds the block in S_DONE. A result may wait while the next item is taken.
// Reset (i_rst_n low, synchronous): queue emptied, reorder depth 0, no result pending.
`include "assert_macros.svh"

module poc_reorder_output_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [proq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_frame_handle,
    input  logic signed [31:0]            i_order_count,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_popped_handle,
    output logic signed [31:0]            o_popped_order,
    output logic [proq_pkg::OCC_W-1:0]    o_occupancy
);

    // Entry memory is not cleared; only entries below the fill level are ever used.
    // S_IDLE : take an item; push and clear update the queue here
    // S_SCAN : stream entries 0..fill-1 out of memory, keep the smallest
    // S_SHIFT: close the gap, read entry j and write it to j-1 (pipelined)
    // S_DONE : hand the result to the output register once it is free
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} t_state;

    t_state                        r_state;
    logic [proq_pkg::CNT_W-1:0]    r_fill;
    logic [proq_pkg::CFG_W-1:0]    r_depth;
    logic [proq_pkg::CNT_W-1:0]    r_scan;     // next address to read in scan
    logic [proq_pkg::CNT_W-1:0]    r_ptr;      // next address to read in shift
    logic                          r_rd_vld;   // shift read in flight
    logic [proq_pkg::IDX_W-1:0]    r_wr_addr;  // where the in-flight read lands
    logic [proq_pkg::IDX_W-1:0]    r_best_idx;
    proq_pkg::t_entry              r_best;

    // pending result
    logic [2:0]                    r_res_status;
    logic [7:0]                    r_res_handle;
    logic [31:0]                   r_res_order;

    // output register
    logic                          r_out_valid;
    logic [2:0]                    r_out_status;
    logic [7:0]                    r_out_handle;
    logic [31:0]                   r_out_order;
    logic [proq_pkg::OCC_W-1:0]    r_out_occ;

    // entry memory, one write and one registered read port
    proq_pkg::t_entry              r_mem [proq_pkg::QUEUE_DEPTH];
    proq_pkg::t_entry              r_rd_data;
    logic                          mem_we;
    logic [proq_pkg::IDX_W-1:0]    mem_waddr;
    proq_pkg::t_entry              mem_wdata;
    logic [proq_pkg::IDX_W-1:0]    rd_addr;

    logic                          full;
    logic                          over_depth;
    logic                          in_acc;
    logic [proq_pkg::IDX_W-1:0]    scan_idx;
    logic                          take_new;
    logic [proq_pkg::IDX_W-1:0]    best_idx_now;

    assign full       = (r_fill == proq_pkg::CNT_W'(proq_pkg::QUEUE_DEPTH));
    assign over_depth = proq_pkg::CMP_W'(r_fill) > proq_pkg::CMP_W'(r_depth);
    assign in_acc     = i_valid && o_ready;

    // entry whose data is in r_rd_data during the scan
    assign scan_idx     = proq_pkg::IDX_W'(r_scan - 1'b1);
    // strict less-than: among equal counts the earliest entry wins
    assign take_new     = (r_scan == proq_pkg::CNT_W'(1)) ||
                          ($signed(r_rd_data.order) < $signed(r_best.order));
    assign best_idx_now = take_new ? scan_idx : r_best_idx;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill[proq_pkg::IDX_W-1:0];
        mem_wdata = '{handle: i_frame_handle, order: i_order_count};
        rd_addr   = '0;
        case (r_state)
            S_IDLE: begin
                // first scan read is issued together with the accept
                rd_addr = '0;
                if (in_acc && i_operation == proq_pkg::OP_PUSH && !full) begin
                    mem_we = 1'b1;
                end
            end
            S_SCAN: begin
                rd_addr = r_scan[proq_pkg::IDX_W-1:0];
            end
            S_SHIFT: begin
                rd_addr = r_ptr[proq_pkg::IDX_W-1:0];
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_addr;
                    mem_wdata = r_rd_data;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // read j while writing j-2 in shift: never the same entry, no forwarding needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_depth     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth <= i_cfg_wr_data;
            end
            // in S_DONE an accepted result is replaced by the pending one below
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_handle <= '0;
                        r_res_order  <= '0;
                        unique case (i_operation) inside
                            proq_pkg::OP_PUSH: begin
                                r_state <= S_DONE;
                                if (full) begin
                                    r_res_status <= proq_pkg::ST_DROPPED;
                                end else begin
                                    r_res_status <= proq_pkg::ST_PUSHED;
                                    r_fill       <= proq_pkg::CNT_W'(r_fill + 1'b1);
                                end
                            end
                            proq_pkg::OP_BUMP_COND, proq_pkg::OP_BUMP_ANY: begin
                                if (r_fill != '0 &&
                                    (i_operation == proq_pkg::OP_BUMP_ANY || over_depth)) begin
                                    r_scan  <= proq_pkg::CNT_W'(1);
                                    r_state <= S_SCAN;
                                end else begin
                                    r_res_status <= proq_pkg::ST_NONE;
                                    r_state      <= S_DONE;
                                end
                            end
                            proq_pkg::OP_CLEAR: begin
                                r_fill       <= '0;
                                r_res_status <= proq_pkg::ST_CLEARED;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (take_new) begin
                        r_best     <= r_rd_data;
                        r_best_idx <= scan_idx;
                    end
                    if (r_scan == r_fill) begin
                        r_ptr    <= proq_pkg::CNT_W'(best_idx_now) + 1'b1;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SHIFT;
                    end else begin
                        r_scan <= proq_pkg::CNT_W'(r_scan + 1'b1);
                    end
                end
                S_SHIFT: begin
                    if (r_ptr < r_fill) begin
                        r_rd_vld  <= 1'b1;
                        r_wr_addr <= proq_pkg::IDX_W'(r_ptr - 1'b1);
                        r_ptr     <= proq_pkg::CNT_W'(r_ptr + 1'b1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_fill       <= proq_pkg::CNT_W'(r_fill - 1'b1);
                            r_res_status <= proq_pkg::ST_POPPED;
                            r_res_handle <= r_best.handle;
                            r_res_order  <= r_best.order;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_handle <= r_res_handle;
                        r_out_order  <= r_res_order;
                        r_out_occ    <= proq_pkg::OCC_W'(r_fill);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_popped_handle = r_out_handle;
    assign o_popped_order  = r_out_order;
    assign o_occupancy     = r_out_occ;

    `ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1,
        r_fill <= proq_pkg::CNT_W'(proq_pkg::QUEUE_DEPTH))
    `ASSERT_IMPL(a_shift_in_range, i_clk, i_rst_n, r_state == S_SHIFT && r_rd_vld,
        proq_pkg::CNT_W'(r_wr_addr) + 1'b1 < r_fill)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_ready)

endmodule

// ===== tb/poc_bump_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the reorder queue, predicts the result of every
// accepted item and compares it with what comes out, in order.
module poc_bump_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [proq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [7:0]                    i_frame_handle,
    input  logic signed [31:0]            i_order_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [2:0]                    i_status,
    input  logic [7:0]                    i_popped_handle,
    input  logic signed [31:0]            i_popped_order,
    input  logic [proq_pkg::OCC_W-1:0]    i_occupancy,
    output int                            o_pending,
    output int                            o_fail_count
);

    typedef struct packed {
        logic [2:0]                 status;
        logic [7:0]                 handle;
        logic [31:0]                order;
        logic [proq_pkg::OCC_W-1:0] occupancy;
    } t_bump_result;

    // shadow of the frame queue, kept in push order
    logic [7:0]                 held_handle [proq_pkg::QUEUE_DEPTH];
    logic signed [31:0]         held_order  [proq_pkg::QUEUE_DEPTH];
    int                         held_count;
    logic [proq_pkg::CFG_W-1:0] depth_setting;

    t_bump_result       due_results [$];
    t_bump_result       predicted;
    t_bump_result       seen;
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic predict_item(input logic [1:0] op, input logic [7:0] handle,
                                input logic signed [31:0] order,
                                output t_bump_result res);
        int  best;
        int  k;
        bit  grant;
        res        = '0;
        res.status = proq_pkg::ST_NONE;
        case (op) inside
            proq_pkg::OP_PUSH: begin
                if (held_count >= proq_pkg::QUEUE_DEPTH) begin
                    res.status = proq_pkg::ST_DROPPED;
                end else begin
                    held_handle[held_count] = handle;
                    held_order[held_count]  = order;
                    held_count++;
                    res.status = proq_pkg::ST_PUSHED;
                end
            end
            proq_pkg::OP_BUMP_COND, proq_pkg::OP_BUMP_ANY: begin
                grant = (held_count > 0);
                if (op == proq_pkg::OP_BUMP_COND && held_count <= int'(depth_setting))
                    grant = 1'b0;
                if (grant) begin
                    // strict less-than keeps the earliest of equal counts
                    best = 0;
                    for (k = 1; k < held_count; k++)
                        if (held_order[k] < held_order[best])
                            best = k;
                    res.handle = held_handle[best];
                    res.order  = held_order[best];
                    for (k = best; k + 1 < held_count; k++) begin
                        held_handle[k] = held_handle[k + 1];
                        held_order[k]  = held_order[k + 1];
                    end
                    held_count--;
                    res.status = proq_pkg::ST_POPPED;
                end
            end
            default: begin
                held_count = 0;
                res.status = proq_pkg::ST_CLEARED;
            end
        endcase
        res.occupancy = proq_pkg::OCC_W'(held_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count    = 0;
            depth_setting = '0;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en)
                depth_setting = i_cfg_wr_data;
            // results are matched before this edge's item is predicted
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no item outstanding: status %0d", i_status);
                    mismatches++;
                end else begin
                    seen = due_results.pop_front();
                    if (i_status !== seen.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               seen.status, i_status);
                        mismatches++;
                    end
                    if (i_popped_handle !== seen.handle) begin
                        $error("popped_handle mismatch: expected %0d, actual %0d",
                               seen.handle, i_popped_handle);
                        mismatches++;
                    end
                    if (i_popped_order !== seen.order) begin
                        $error("popped_order mismatch: expected %0d, actual %0d",
                               $signed(seen.order), i_popped_order);
                        mismatches++;
                    end
                    if (i_occupancy !== seen.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               seen.occupancy, i_occupancy);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_operation, i_frame_handle, i_order_count, predicted);
                due_results.push_back(predicted);
            end
            o_pending <= due_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the reorder output queue. The checker instance
// beside the block does all prediction and comparison.
module testbench;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1550;
    // covers the longest pop plus the longest gap that either side inserts
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 50;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [proq_pkg::CFG_W-1:0]    i_cfg_wr_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [1:0]                    i_operation;
    logic [7:0]                    i_frame_handle;
    logic signed [31:0]            i_order_count;
    logic                          o_valid;
    logic                          i_ready;
    logic [2:0]                    o_status;
    logic [7:0]                    o_popped_handle;
    logic signed [31:0]            o_popped_order;
    logic [proq_pkg::OCC_W-1:0]    o_occupancy;

    int                   results_pending;
    int                   fail_count;
    int                   stall_cycles;

    // when set, neither side inserts gaps
    bit                   steady = 1'b0;
    int                   items_sent = 0;

    // directed order counts: both extremes, around zero, and repeats for ties
    logic [31:0] corner_orders [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                       32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};

    int                   phase;
    int                   span;
    int                   push_pct;
    int                   roll;
    int                   pts_base;
    int                   n;
    logic [1:0]           op;
    logic [31:0]          order;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    poc_reorder_output_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_frame_handle  (i_frame_handle),
        .i_order_count   (i_order_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_popped_handle (o_popped_handle),
        .o_popped_order  (o_popped_order),
        .o_occupancy     (o_occupancy)
    );

    poc_bump_checker order_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_operation     (i_operation),
        .i_frame_handle  (i_frame_handle),
        .i_order_count   (i_order_count),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_status        (o_status),
        .i_popped_handle (o_popped_handle),
        .i_popped_order  (o_popped_order),
        .i_occupancy     (o_occupancy),
        .o_pending       (results_pending),
        .o_fail_count    (fail_count)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one item and hold it until accepted. Valid is left high on
    // return so back-to-back items never drop it within a time step.
    task automatic send_item(input logic [1:0] item_op, input logic [7:0] handle,
                             input logic [31:0] count);
        int idle;
        idle = pick_gap();
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= item_op;
        i_frame_handle <= handle;
        i_order_count  <= count;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Stop presenting items and wait for every outstanding result.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // Depth is only changed with the queue quiet and nothing in flight.
    task automatic set_reorder_depth(input int depth);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= proq_pkg::CFG_W'(depth);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random stalls, independent of the item side.
    initial begin
        int idle;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            idle = pick_gap();
            if (idle > 0) begin
                i_ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watchdog: any stretch without a handshake on either channel is a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("poc_reorder_output_queue_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_valid        <= 1'b0;
        i_operation    <= proq_pkg::OP_PUSH;
        i_frame_handle <= '0;
        i_order_count  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reorder depth at its reset value of 0 ----
        // bumps on an empty queue return nothing
        send_item(proq_pkg::OP_BUMP_ANY, 8'hFF, 32'hFFFF_FFFF);
        send_item(proq_pkg::OP_BUMP_COND, 8'hFF, 32'hFFFF_FFFF);
        // fill to the top: handles 0x00..0xFF, order counts at both extremes
        // with repeated values so ties are present
        for (n = 0; n < proq_pkg::QUEUE_DEPTH; n++)
            send_item(proq_pkg::OP_PUSH, 8'(n * 17), corner_orders[n % 6]);
        // one more push while full is dropped
        send_item(proq_pkg::OP_PUSH, 8'hC3, 32'h8000_0000);
        // depth equal to the queue size: conditional bump never releases
        set_reorder_depth(proq_pkg::QUEUE_DEPTH);
        send_item(proq_pkg::OP_BUMP_COND, 8'h00, 32'h0);
        // one below full: conditional bump releases the oldest minimum
        set_reorder_depth(proq_pkg::QUEUE_DEPTH - 1);
        send_item(proq_pkg::OP_BUMP_COND, 8'h00, 32'h0);
        // the remaining two minimum counts must leave in push order
        send_item(proq_pkg::OP_BUMP_ANY, 8'h00, 32'h0);
        send_item(proq_pkg::OP_BUMP_ANY, 8'h00, 32'h0);
        // clear, then confirm the queue really is empty
        send_item(proq_pkg::OP_CLEAR, 8'hA5, 32'h5A5A_5A5A);
        send_item(proq_pkg::OP_BUMP_ANY, 8'h00, 32'h0);

        // ---- random part, in phases with their own depth and op mix ----
        phase    = 0;
        pts_base = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // extremes of the depth first, then anything in range
            case (phase)
                0:       set_reorder_depth(proq_pkg::QUEUE_DEPTH);
                1:       set_reorder_depth(0);
                default: set_reorder_depth($urandom_range(0, proq_pkg::QUEUE_DEPTH));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            // push-heavy phases run into a full queue, pop-heavy ones drain it
            case ($urandom_range(0, 2))
                0:       push_pct = 35;
                1:       push_pct = 55;
                default: push_pct = 75;
            endcase
            span = $urandom_range(40, 120);
            repeat (span) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    op = proq_pkg::OP_PUSH;
                else if (roll >= 97)
                    op = proq_pkg::OP_CLEAR;
                else if (roll < push_pct + (97 - push_pct) / 2)
                    op = proq_pkg::OP_BUMP_COND;
                else
                    op = proq_pkg::OP_BUMP_ANY;
                // order count shapes: tight cluster for ties, raw 32 bits,
                // near the signed limits, and a rising display sequence
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    order = 32'($urandom_range(0, 7)) - 32'd4;
                end else if (roll < 70) begin
                    order = $urandom;
                end else if (roll < 85) begin
                    if ($urandom_range(0, 1))
                        order = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
                    else
                        order = 32'h8000_0000 + 32'($urandom_range(0, 3));
                end else begin
                    pts_base += $urandom_range(0, 4);
                    order = 32'(pts_base) + 32'($urandom_range(0, 6)) - 32'd3;
                end
                send_item(op, 8'($urandom_range(0, 255)), order);
            end
            phase++;
        end
        steady = 1'b0;

        // let every result arrive, then watch a little longer for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("poc_reorder_output_queue_top regression: pass");
        else
            $display("poc_reorder_output_queue_top regression: fail");
        $finish;
    end

endmodule

// ===== poc_reorder_output_queue_top.f =====
+incdir+sv
sv/proq_pkg.sv
sv/poc_reorder_output_queue_top.sv
tb/poc_bump_checker.sv
tb/testbench.sv
